// ===== design/mxq_pkg.sv =====
// Shared types and constants for the max-XOR-with-limit trie block.
// Used by the trie level cell and by the top level; no dependencies.
`timescale 1ns / 1ps

package mxq_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_ENTRIES = 1024;
    localparam int PTR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_FOUND = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef struct packed {
        logic                  valid;
        logic [PTR_W-1:0]      ptr;
        logic [VALUE_BITS-1:0] min_val;
    } slot_t;

    typedef struct packed {
        slot_t c1;
        slot_t c0;
    } node_t;

    typedef struct packed {
        logic                  is_query;
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] limit;
        logic [VALUE_BITS-1:0] path;
        logic [VALUE_BITS-1:0] ans;
        logic [PTR_W-1:0]      ptr;
        logic                  is_new;
        logic                  none;
    } tok_t;

endpackage

// ===== design/max_xor_query_with_limit.sv =====
// Top level of the max-XOR-with-limit block: handshake, entry count and a chain
// of trie level cells, one per value bit. Depends on mxq_pkg and mxq_cell.
//
//   Channel   Direction   Fields                      Handshake
//   req       in          operation, value, limit     req_valid / req_stall
//   rsp       out         status, max_xor             rsp_valid / rsp_stall
//
// An insert or query passes from acceptance through the trie level cells, one
// per trie level, each level holding its own node memory, to a registered result.
// A clear, a rejected insert or an unused code gives its result in the next cycle.
// One transaction is in the block at a time; a new one is taken as the result leaves.
// Reset is asynchronous and empties the set at once; node memories need no sweep.
// A stalled result holds its register and blocks new transactions.
`timescale 1ns / 1ps

module max_xor_query_with_limit
    import mxq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            operation,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [VALUE_BITS-1:0] limit,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic [VALUE_BITS-1:0] max_xor
);

    logic                  busy_reg;
    logic                  root_valid_reg;
    logic [CNT_W-1:0]      entry_count_reg;
    logic                  rsp_valid_reg;
    logic [1:0]            status_reg;
    logic [VALUE_BITS-1:0] max_xor_reg;

    logic accept;
    logic is_chain;
    logic is_clear;
    logic has_room;

    logic chain_valid [VALUE_BITS+1];
    tok_t chain_tok   [VALUE_BITS+1];

    always_comb
    begin
        req_stall = busy_reg || (rsp_valid_reg && rsp_stall);
        accept    = req_valid && !req_stall;
        has_room  = entry_count_reg < CNT_W'(MAX_ENTRIES);
        is_clear  = (operation == OP_CLEAR);
        is_chain  = (operation == OP_QUERY) || ((operation == OP_INSERT) && has_room);

        chain_valid[0]        = accept && is_chain;
        chain_tok[0].is_query = (operation == OP_QUERY);
        chain_tok[0].value    = value;
        chain_tok[0].limit    = limit;
        chain_tok[0].path     = value;
        chain_tok[0].ans      = '0;
        chain_tok[0].ptr      = '0;
        chain_tok[0].is_new   = !root_valid_reg;
        chain_tok[0].none     = 1'b0;
    end

    for (genvar g = 0; g < VALUE_BITS; g++)
    begin : g_level
        mxq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (accept && is_clear),
            .in_valid  (chain_valid[g]),
            .in_tok    (chain_tok[g]),
            .out_valid (chain_valid[g+1]),
            .out_tok   (chain_tok[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            root_valid_reg  <= 1'b0;
            entry_count_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (chain_valid[VALUE_BITS])
            begin
                busy_reg <= 1'b0;
            end
            else if (accept && is_chain)
            begin
                busy_reg <= 1'b1;
            end

            if (accept && is_clear)
            begin
                root_valid_reg  <= 1'b0;
                entry_count_reg <= '0;
            end
            else if (accept && is_chain && (operation == OP_INSERT))
            begin
                root_valid_reg  <= 1'b1;
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end

            if (chain_valid[VALUE_BITS] || (accept && !is_chain))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[VALUE_BITS])
        begin
            if (!chain_tok[VALUE_BITS].is_query)
            begin
                status_reg  <= ST_DONE;
                max_xor_reg <= '0;
            end
            else if (chain_tok[VALUE_BITS].none)
            begin
                status_reg  <= ST_NONE;
                max_xor_reg <= '0;
            end
            else
            begin
                status_reg  <= ST_FOUND;
                max_xor_reg <= chain_tok[VALUE_BITS].ans;
            end
        end
        else if (accept && !is_chain)
        begin
            status_reg  <= (operation == OP_INSERT) ? ST_FULL : ST_DONE;
            max_xor_reg <= '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign max_xor   = max_xor_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds capacity");

    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && rsp_valid_reg))
        else $error("result held while a transaction is still in the chain");

    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[VALUE_BITS] |-> busy_reg)
        else $error("chain produced a result with no transaction in flight");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_clear) |=> (rsp_valid_reg && (status_reg == ST_DONE)
                                  && (entry_count_reg == '0) && !root_valid_reg))
        else $error("clear did not empty the set and report done");

endmodule

// ===== design/mxq_cell.sv =====
// One trie level: a node memory for this depth plus a token stage.
// Depends on mxq_pkg for the node, slot and token types.
`timescale 1ns / 1ps

module mxq_cell
    import mxq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  logic in_valid,
    input  tok_t in_tok,
    output logic out_valid,
    output tok_t out_tok
);

    node_t node_mem [MAX_ENTRIES];

    logic             stage_valid_reg;
    tok_t             stage_reg;
    node_t            rdata_reg;
    logic [CNT_W-1:0] child_count_reg;

    node_t node_cur;
    node_t node_wr;
    slot_t slot_b;
    slot_t slot_w;
    slot_t slot_new;
    logic  bit_b;
    logic  usable_w;
    logic  usable_b;
    logic  alloc;

    always_comb
    begin
        node_cur = stage_reg.is_new ? '0 : rdata_reg;
        bit_b    = stage_reg.path[VALUE_BITS-1];
        slot_b   = bit_b ? node_cur.c1 : node_cur.c0;
        slot_w   = bit_b ? node_cur.c0 : node_cur.c1;
        usable_w = slot_w.valid && (slot_w.min_val <= stage_reg.limit);
        usable_b = slot_b.valid && (slot_b.min_val <= stage_reg.limit);
        alloc    = !slot_b.valid;

        slot_new = slot_b;
        if (alloc)
        begin
            slot_new.valid   = 1'b1;
            slot_new.ptr     = child_count_reg[PTR_W-1:0];
            slot_new.min_val = stage_reg.value;
        end
        else if (stage_reg.value < slot_b.min_val)
        begin
            slot_new.min_val = stage_reg.value;
        end

        node_wr = node_cur;
        if (bit_b)
        begin
            node_wr.c1 = slot_new;
        end
        else
        begin
            node_wr.c0 = slot_new;
        end

        out_tok      = stage_reg;
        out_tok.path = stage_reg.path << 1;
        if (stage_reg.is_query)
        begin
            out_tok.ans    = (stage_reg.ans << 1) | VALUE_BITS'(usable_w);
            out_tok.ptr    = usable_w ? slot_w.ptr : slot_b.ptr;
            out_tok.is_new = 1'b0;
            out_tok.none   = stage_reg.none || (!usable_w && !usable_b);
        end
        else
        begin
            out_tok.ptr    = slot_new.ptr;
            out_tok.is_new = alloc;
        end
        out_valid = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            child_count_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= in_valid;
            if (clear)
            begin
                child_count_reg <= '0;
            end
            else if (stage_valid_reg && !stage_reg.is_query && alloc)
            begin
                child_count_reg <= child_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= in_tok;
            rdata_reg <= node_mem[in_tok.ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg && !stage_reg.is_query)
        begin
            node_mem[stage_reg.ptr] <= node_wr;
        end
    end

endmodule
